>>> rtl/core/kmdb_pkg.sv
// shared types and constants for the key matrix debounce block
// used by kmdb_front, kmdb_fifo, kmdb_back and key_matrix_debounce_make_break
// no dependencies
package kmdb_pkg;

  localparam int unsigned CODE_W    = 8;
  localparam int unsigned SLOTS     = 4;
  localparam int unsigned WORD_W    = CODE_W * SLOTS;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned STEP_W    = 8;
  localparam int unsigned TIMER_W   = 17;
  localparam int unsigned MASK_W    = 2 * SLOTS;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  // register index codes (byte address bit 2)
  localparam logic REG_HOLD_LIMIT = 1'b0;
  localparam logic REG_HOLD_STEP  = 1'b1;

  localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST = LIMIT_W'(30);
  localparam logic [STEP_W-1:0]  HOLD_STEP_RST  = STEP_W'(10);

  typedef struct packed {
    logic [WORD_W-1:0] scan_word;
    logic [TIME_W-1:0] scan_time;
  } scan_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic              is_release;
    logic [TIME_W-1:0] event_time;
    logic              last_event;
  } key_event_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] hold_limit;
    logic [STEP_W-1:0]  hold_step;
  } cfg_t;

  // one reported change: mask bits 0..3 are makes from new_word bytes,
  // bits 4..7 are breaks from old_word bytes
  typedef struct packed {
    logic [WORD_W-1:0] new_word;
    logic [WORD_W-1:0] old_word;
    logic [TIME_W-1:0] scan_time;
    logic [MASK_W-1:0] mask;
  } job_t;

endpackage

>>> rtl/core/kmdb_front.sv
// front end: takes scans, runs the hold timer and builds event masks
// depends on kmdb_pkg
module kmdb_front (
  input  logic               clk,
  input  logic               rst,
  input  kmdb_pkg::cfg_t     cfg,
  input  logic               scan_valid,
  input  kmdb_pkg::scan_t    scan,
  output logic               scan_stall,
  input  logic               job_full,
  output logic               job_push,
  output kmdb_pkg::job_t     job
);

  logic [kmdb_pkg::WORD_W-1:0]  sampled_word, sampled_word_next;
  logic [kmdb_pkg::WORD_W-1:0]  reported_word, reported_word_next;
  logic [kmdb_pkg::TIMER_W-1:0] hold_timer, hold_timer_next;
  logic                         accept;
  logic                         report;
  logic [kmdb_pkg::MASK_W-1:0]  mask;

  assign scan_stall = job_full;
  assign accept     = scan_valid && !scan_stall;

  always_comb begin
    sampled_word_next = sampled_word;
    hold_timer_next   = hold_timer;
    if (scan.scan_word != sampled_word) begin
      sampled_word_next = scan.scan_word;
      hold_timer_next   = '0;
    end else if (hold_timer < {1'b0, cfg.hold_limit}) begin
      hold_timer_next = hold_timer +
                        {{(kmdb_pkg::TIMER_W - kmdb_pkg::STEP_W){1'b0}}, cfg.hold_step};
    end
  end

  assign report = (reported_word != sampled_word_next) &&
                  (hold_timer_next >= {1'b0, cfg.hold_limit});

  // make: nonzero new code absent from old word; break: the reverse
  always_comb begin
    logic hit_old, hit_new;
    logic [kmdb_pkg::CODE_W-1:0] c_new, c_old;
    mask = '0;
    for (int i = 0; i < kmdb_pkg::SLOTS; i++) begin
      c_new   = sampled_word_next[i*kmdb_pkg::CODE_W +: kmdb_pkg::CODE_W];
      c_old   = reported_word[i*kmdb_pkg::CODE_W +: kmdb_pkg::CODE_W];
      hit_old = 1'b0;
      hit_new = 1'b0;
      for (int j = 0; j < kmdb_pkg::SLOTS; j++) begin
        if (reported_word[j*kmdb_pkg::CODE_W +: kmdb_pkg::CODE_W] == c_new)
          hit_old = 1'b1;
        if (sampled_word_next[j*kmdb_pkg::CODE_W +: kmdb_pkg::CODE_W] == c_old)
          hit_new = 1'b1;
      end
      mask[i]                  = (c_new != '0) && !hit_old;
      mask[i + kmdb_pkg::SLOTS] = (c_old != '0) && !hit_new;
    end
  end

  assign reported_word_next = report ? sampled_word_next : reported_word;

  assign job_push       = accept && report && (mask != '0);
  assign job.new_word   = sampled_word_next;
  assign job.old_word   = reported_word;
  assign job.scan_time  = scan.scan_time;
  assign job.mask       = mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      sampled_word  <= '0;
      reported_word <= '0;
      hold_timer    <= '0;
    end else if (accept) begin
      sampled_word  <= sampled_word_next;
      reported_word <= reported_word_next;
      hold_timer    <= hold_timer_next;
    end
  end

endmodule

>>> rtl/core/kmdb_fifo.sv
// short job queue between front and back ends
// depends on kmdb_pkg
module kmdb_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kmdb_pkg::job_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output kmdb_pkg::job_t  pop_data
);

  kmdb_pkg::job_t                 entries [kmdb_pkg::FIFO_DEPTH];
  logic [kmdb_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [kmdb_pkg::FIFO_CNT_W-1:0] count;
  logic                            do_push, do_pop;

  assign full      = (count == kmdb_pkg::FIFO_CNT_W'(kmdb_pkg::FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/kmdb_back.sv
// back end: one event per unstalled cycle from a job's mask into output register
// depends on kmdb_pkg
module kmdb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_ready,
  input  kmdb_pkg::job_t       job_in,
  output logic                 job_pop,
  output logic                 key_valid,
  input  logic                 key_stall,
  output kmdb_pkg::key_event_t key_event
);

  kmdb_pkg::job_t              job;
  logic                        job_valid;
  logic                        slot_free;
  logic                        emit;
  logic                        last;
  logic [kmdb_pkg::MASK_W-1:0] mask_rest;
  logic [$clog2(kmdb_pkg::MASK_W)-1:0] sel;
  logic [kmdb_pkg::CODE_W-1:0] sel_code;
  logic                        sel_break;

  assign slot_free = !key_valid || !key_stall;
  assign emit      = job_valid && slot_free;
  assign mask_rest = job.mask & (job.mask - 1'b1);
  assign last      = (mask_rest == '0);
  assign job_pop   = job_ready && (!job_valid || (emit && last));

  // lowest pending event first: makes in byte order, then breaks
  always_comb begin
    sel = '0;
    for (int i = kmdb_pkg::MASK_W - 1; i >= 0; i--) begin
      if (job.mask[i]) sel = ($clog2(kmdb_pkg::MASK_W))'(i);
    end
  end

  assign sel_break = sel[$clog2(kmdb_pkg::MASK_W)-1];

  always_comb begin
    logic [$clog2(kmdb_pkg::SLOTS)-1:0] slot;
    slot     = sel[$clog2(kmdb_pkg::SLOTS)-1:0];
    sel_code = sel_break ? job.old_word[slot*kmdb_pkg::CODE_W +: kmdb_pkg::CODE_W]
                         : job.new_word[slot*kmdb_pkg::CODE_W +: kmdb_pkg::CODE_W];
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_in;
    end else if (emit) begin
      job.mask <= mask_rest;
    end
    if (emit) begin
      key_event.key_code   <= sel_code;
      key_event.is_release <= sel_break;
      key_event.event_time <= job.scan_time;
      key_event.last_event <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      key_valid <= 1'b0;
    end else begin
      if (job_pop)            job_valid <= 1'b1;
      else if (emit && last)  job_valid <= 1'b0;
      if (emit)               key_valid <= 1'b1;
      else if (!key_stall)    key_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/key_matrix_debounce_make_break.sv
// top level of the keyboard scan debouncer with make/break event output
// instantiates kmdb_front, kmdb_fifo, kmdb_back; uses kmdb_pkg
//
// Each request on the scan channel is one keyboard scan: four 8-bit key codes
// (0 = empty) and a timestamp. A changed word restarts the hold timer; an
// unchanged one adds hold_step until the timer reaches hold_limit. Once stable
// and different from the last reported word, the block emits make events for
// new codes (byte order 0..3), then break events for released codes, each
// stamped with the scan time, last_event set on the final one. Scans are
// taken one per cycle while the queue is not full; the front end decides the
// events in the accept cycle and places a job in a four-entry queue. The back
// end drains one event per cycle through the output register while key_stall
// is low, and a scan yields at most 8 events. Scan stall rises only while the
// queue is full. Registers: hold_limit at 0x0 (reset 30), hold_step at 0x4
// (reset 10), write them only while the block is idle.
module key_matrix_debounce_make_break (
  input  logic                          clk,
  input  logic                          rst,
  // scan requests
  input  logic                          scan_valid,
  output logic                          scan_stall,
  input  kmdb_pkg::scan_t               scan,
  // key event requests
  output logic                          key_valid,
  input  logic                          key_stall,
  output kmdb_pkg::key_event_t          key_event,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kmdb_pkg::ADDR_W-1:0]   paddr,
  input  logic [kmdb_pkg::DATA_W-1:0]   pwdata,
  output logic [kmdb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  kmdb_pkg::cfg_t cfg;
  kmdb_pkg::job_t front_job, back_job;
  logic           job_push, job_full, job_pop, job_ready;
  logic           reg_idx;

  // register file, never waits
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_limit <= kmdb_pkg::HOLD_LIMIT_RST;
      cfg.hold_step  <= kmdb_pkg::HOLD_STEP_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        kmdb_pkg::REG_HOLD_LIMIT: cfg.hold_limit <= pwdata[kmdb_pkg::LIMIT_W-1:0];
        kmdb_pkg::REG_HOLD_STEP:  cfg.hold_step  <= pwdata[kmdb_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      kmdb_pkg::REG_HOLD_LIMIT:
        prdata = {{(kmdb_pkg::DATA_W - kmdb_pkg::LIMIT_W){1'b0}}, cfg.hold_limit};
      kmdb_pkg::REG_HOLD_STEP:
        prdata = {{(kmdb_pkg::DATA_W - kmdb_pkg::STEP_W){1'b0}}, cfg.hold_step};
      default: prdata = '0;
    endcase
  end

  // front end: debounce and event classification
  kmdb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .scan_valid (scan_valid),
    .scan       (scan),
    .scan_stall (scan_stall),
    .job_full   (job_full),
    .job_push   (job_push),
    .job        (front_job)
  );

  // decouples scan acceptance from event draining
  kmdb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (front_job),
    .full      (job_full),
    .pop       (job_pop),
    .not_empty (job_ready),
    .pop_data  (back_job)
  );

  // back end: serializes events to the output
  kmdb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_ready (job_ready),
    .job_in    (back_job),
    .job_pop   (job_pop),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_event (key_event)
  );

endmodule
